/* src/pcd_pkg.sv */
package pcd_pkg;

    // Datapath width of the shared adder.
    localparam int AluW = 40;
    localparam int MaxChannels = 8;

    // Configuration register indexes.
    localparam logic CFG_SAMPLE_FORMAT = 1'b0;
    localparam logic CFG_CHANNEL_COUNT = 1'b1;

    // Float32 to PCM16 scale and the clamped full-scale result.
    localparam logic [15:0] FULL_SCALE = 16'sd32767;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_RND,
        S_CVT,
        S_ACC,
        S_ABS,
        S_DIV,
        S_NEG
    } state_t;

    // Operands and mode of the shared adder.
    typedef struct packed {
        logic [AluW-1:0] a;
        logic [AluW-1:0] b;
        logic            sub;
    } alu_req_t;

endpackage

/* src/pcm_convert_and_downmix_core.sv */
// A PCM or special float sample goes straight to accumulate; a normal float first
// passes the multiply, round and convert steps. The last channel of a frame then adds
// the magnitude step, the 19-step restoring divide and the sign step.
// A new sample is taken only in the idle state, once the last one is through, and the
// sign step waits while a held result is not taken; all steps share the single 40-bit adder.
// Reset (aresetn low, synchronous): format PCM16, two channels, empty frame,
// no result pending.
module pcm_convert_and_downmix_core
    import pcd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_addr,
    input  logic [3:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // sample_word[31:0]
    input  logic        s_tuser,   // silent
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // mono_sample[15:0]
);

    state_t             state_reg, state_next;
    logic               fmt_reg;
    logic [3:0]         cc_reg;
    logic [2:0]         pos_reg, pos_next;
    logic signed [18:0] sum_reg, sum_next;
    logic [31:0]        word_reg, word_next;
    logic [38:0]        prod_reg, prod_next;
    logic [24:0]        rnd_reg, rnd_next;
    logic               shf_reg, shf_next;
    logic signed [15:0] smp_reg, smp_next;
    logic [18:0]        dvd_reg, dvd_next;
    logic [2:0]         rem_reg, rem_next;
    logic [4:0]         cnt_reg, cnt_next;
    logic               neg_reg, neg_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [15:0]        m_tdata_reg, m_tdata_next;

    alu_req_t           alu_req;
    logic [AluW-1:0]    alu_y;
    logic [3:0]         n_eff;
    logic [23:0]        mant;
    logic [7:0]         fexp;
    logic [7:0]         shamt;
    logic [24:0]        mag_full;
    logic [23:0]        trunc;
    logic               guard, sticky;
    logic [3:0]         trial;

    pcd_alu u_alu (
        .req (alu_req),
        .y   (alu_y)
    );

    // Effective channel count: zero acts as one, large values saturate.
    always_comb begin
        if (cc_reg == 4'd0) begin
            n_eff = 4'd1;
        end else if (cc_reg > 4'(MaxChannels)) begin
            n_eff = 4'(MaxChannels);
        end else begin
            n_eff = cc_reg;
        end
    end

    // The rounded value keeps the product shifted down by 14 or 15 bits, so the
    // integer part lies 136 - exponent (one less when the product carried) bits down.
    assign mant  = {1'b1, word_reg[22:0]};
    assign fexp  = word_reg[30:23];
    assign shamt = 8'd136 - fexp - {7'd0, shf_reg};
    assign mag_full = (shamt > 8'd24) ? 25'd0 : (rnd_reg >> shamt[4:0]);
    assign trunc  = prod_reg[38] ? prod_reg[38:15] : prod_reg[37:14];
    assign guard  = prod_reg[38] ? prod_reg[14] : prod_reg[13];
    assign sticky = prod_reg[38] ? (|prod_reg[13:0]) : (|prod_reg[12:0]);
    assign trial  = {rem_reg, dvd_reg[18]};

    // Sequencer: next state, shared-adder operands and datapath updates.
    always_comb begin
        state_next    = state_reg;
        pos_next      = pos_reg;
        sum_next      = sum_reg;
        word_next     = word_reg;
        prod_next     = prod_reg;
        rnd_next      = rnd_reg;
        shf_next      = shf_reg;
        smp_next      = smp_reg;
        dvd_next      = dvd_reg;
        rem_next      = rem_reg;
        cnt_next      = cnt_reg;
        neg_next      = neg_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        alu_req       = '0;
        s_tready      = (state_reg == S_IDLE);

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    word_next  = s_tdata;
                    state_next = S_ACC;
                    if (s_tuser) begin
                        smp_next = '0;
                    end else if (!fmt_reg) begin
                        smp_next = s_tdata[15:0];
                    end else if (s_tdata[30:23] == 8'hFF && s_tdata[22:0] != 23'd0) begin
                        smp_next = '0;
                    end else if (s_tdata[30:23] >= 8'd127) begin
                        smp_next = s_tdata[31] ? -FULL_SCALE : FULL_SCALE;
                    end else if (s_tdata[30:23] == 8'd0) begin
                        smp_next = '0;
                    end else begin
                        state_next = S_MUL;
                    end
                end
            end
            // Mantissa times 32767 as (m << 15) - m.
            S_MUL: begin
                alu_req.a  = AluW'({mant, 15'd0});
                alu_req.b  = AluW'(mant);
                alu_req.sub = 1'b1;
                prod_next  = alu_y[38:0];
                state_next = S_RND;
            end
            // Round the product to 24 significant bits, nearest even.
            S_RND: begin
                alu_req.a  = AluW'(trunc);
                alu_req.b  = AluW'(guard & (sticky | trunc[0]));
                rnd_next   = alu_y[24:0];
                shf_next   = prod_reg[38];
                state_next = S_CVT;
            end
            // Truncate toward zero and apply the sign.
            S_CVT: begin
                alu_req.b   = AluW'(mag_full[15:0]);
                alu_req.sub = word_reg[31];
                smp_next    = word_reg[31] ? alu_y[15:0] : mag_full[15:0];
                state_next  = S_ACC;
            end
            S_ACC: begin
                alu_req.a = AluW'(signed'(sum_reg));
                alu_req.b = AluW'(signed'(smp_reg));
                sum_next  = alu_y[18:0];
                if ({1'b0, pos_reg} + 4'd1 >= n_eff) begin
                    state_next = S_ABS;
                end else begin
                    pos_next   = pos_reg + 3'd1;
                    state_next = S_IDLE;
                end
            end
            // Magnitude of the frame sum for the unsigned divide.
            S_ABS: begin
                alu_req.b   = AluW'(sum_reg);
                alu_req.sub = sum_reg[18];
                dvd_next    = sum_reg[18] ? alu_y[18:0] : sum_reg;
                neg_next    = sum_reg[18];
                rem_next    = '0;
                cnt_next    = '0;
                state_next  = S_DIV;
            end
            // One restoring-divide step per cycle, quotient shifts into the dividend.
            S_DIV: begin
                alu_req.a   = AluW'(trial);
                alu_req.b   = AluW'(n_eff);
                alu_req.sub = 1'b1;
                if (alu_y[AluW-1]) begin
                    rem_next = trial[2:0];
                    dvd_next = {dvd_reg[17:0], 1'b0};
                end else begin
                    rem_next = alu_y[2:0];
                    dvd_next = {dvd_reg[17:0], 1'b1};
                end
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd18) begin
                    state_next = S_NEG;
                end
            end
            // Restore the sign and hand the result to the output register.
            S_NEG: begin
                alu_req.b   = AluW'(dvd_reg);
                alu_req.sub = neg_reg;
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = neg_reg ? alu_y[15:0] : dvd_reg[15:0];
                    sum_next      = '0;
                    pos_next      = '0;
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        // A channel-count write starts a fresh frame.
        if (cfg_wr_en && cfg_addr == CFG_CHANNEL_COUNT) begin
            sum_next = '0;
            pos_next = '0;
        end
    end

    // Control and configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            fmt_reg      <= 1'b0;
            cc_reg       <= 4'd2;
            pos_reg      <= '0;
            sum_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            pos_reg      <= pos_next;
            sum_reg      <= sum_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    CFG_SAMPLE_FORMAT: fmt_reg <= cfg_wdata[0];
                    CFG_CHANNEL_COUNT: cc_reg  <= cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        word_reg    <= word_next;
        prod_reg    <= prod_next;
        rnd_reg     <= rnd_next;
        shf_reg     <= shf_next;
        smp_reg     <= smp_next;
        dvd_reg     <= dvd_next;
        rem_reg     <= rem_next;
        cnt_reg     <= cnt_next;
        neg_reg     <= neg_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // The divide never runs past its nineteenth step.
    a_div_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DIV) |-> (cnt_reg <= 5'd18))
        else $error("divide step counter overran");

    // After the divide the remainder is below the channel count.
    a_rem_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_NEG) |-> ({1'b0, rem_reg} < n_eff))
        else $error("divide remainder out of range");

    // Delivering a frame result leaves an empty frame behind.
    a_frame_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_NEG && state_next == S_IDLE) |=> (pos_reg == 3'd0 && sum_reg == '0))
        else $error("frame state not cleared after result");

    // The channel position stays below the effective channel count.
    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |-> ({1'b0, pos_reg} < n_eff))
        else $error("channel position beyond frame");

endmodule

/* src/pcd_alu.sv */
module pcd_alu
    import pcd_pkg::*;
(
    input  alu_req_t        req,
    output logic [AluW-1:0] y
);

    // One adder serves add, subtract, compare and negate.
    assign y = req.a + (req.sub ? ~req.b : req.b) + {{(AluW-1){1'b0}}, req.sub};

endmodule

/* bench/pcd_checker.sv */
`default_nettype none

module pcd_checker
    import pcd_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_addr,
    input  wire logic [3:0]  cfg_wdata,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [31:0] s_tdata,
    input  wire logic        s_tuser,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [15:0] m_tdata,
    output int               fail_count,
    output int               pending_count,
    output int               frame_count
);
    timeunit 1ns;
    timeprecision 1ps;

    // Shadow of the block's configuration and frame state.
    logic        float_mode;
    logic [3:0]  chan_setting;
    int          chan_index;
    int          frame_sum;
    logic [15:0] mono_queue[$];

    // Converts a float32 bit pattern to a PCM16 value: clamp to [-1,1], scale by
    // 32767 with round to nearest even at 24 bits, then truncate toward zero.
    function automatic int float_to_pcm(logic [31:0] w);
        logic [7:0]  ex;
        logic [23:0] man;
        logic [38:0] prod;
        logic [38:0] rem;
        logic [38:0] half;
        logic [39:0] kept;
        int          msb;
        int          drop;
        int          sh;
        int          mag;
        ex = w[30:23];
        if (ex == 8'hFF && w[22:0] != 0) return 0;
        if (ex >= 8'd127) return w[31] ? -32767 : 32767;
        man = (ex == 0) ? {1'b0, w[22:0]} : {1'b1, w[22:0]};
        prod = 39'(man) * 39'd32767;
        if (prod == 0) return 0;
        msb = 0;
        for (int i = 0; i < 39; i++) begin
            if (prod[i]) msb = i;
        end
        drop = (msb > 23) ? msb - 23 : 0;
        kept = 40'(prod >> drop);
        if (drop > 0) begin
            rem = prod & ((39'd1 << drop) - 39'd1);
            half = 39'd1 << (drop - 1);
            if (rem > half || (rem == half && kept[0])) kept = kept + 40'd1;
        end
        // The scaled value is always below 2**15, so the exponent is negative here.
        sh = drop + ((ex == 0) ? 1 : int'(ex)) - 150;
        if (sh >= 0) mag = int'(kept << sh);
        else if (-sh >= 40) mag = 0;
        else mag = int'(kept >> (-sh));
        return w[31] ? -mag : mag;
    endfunction

    // Adds one sample to the frame and queues the average when the frame closes.
    function automatic void accumulate_sample(logic [31:0] word, logic silent);
        int n;
        int val;
        n = (chan_setting == 0) ? 1 : (chan_setting > MaxChannels) ? MaxChannels
            : int'(chan_setting);
        if (silent) val = 0;
        else if (float_mode) val = float_to_pcm(word);
        else val = int'($signed(word[15:0]));
        frame_sum += val;
        chan_index++;
        if (chan_index >= n) begin
            mono_queue.push_back(16'(frame_sum / n));
            frame_sum = 0;
            chan_index = 0;
        end
    endfunction

    assign pending_count = mono_queue.size();

    // Track configuration, predict on input transactions, compare on output ones.
    always @(posedge aclk) begin
        if (!aresetn) begin
            float_mode <= 1'b0;
            chan_setting <= 4'd2;
            chan_index = 0;
            frame_sum = 0;
            mono_queue.delete();
            fail_count <= 0;
            frame_count <= 0;
        end else begin
            if (cfg_wr_en) begin
                if (cfg_addr == CFG_SAMPLE_FORMAT) begin
                    float_mode <= cfg_wdata[0];
                end else begin
                    chan_setting <= cfg_wdata;
                    chan_index = 0;
                    frame_sum = 0;
                end
            end
            if (m_tvalid && m_tready) begin
                frame_count <= frame_count + 1;
                if (mono_queue.size() == 0) begin
                    $error("unexpected output transaction: mono_sample actual %0d",
                           $signed(m_tdata));
                    fail_count <= fail_count + 1;
                end else begin
                    if (m_tdata !== mono_queue[0]) begin
                        $error("mono_sample mismatch: expected %0d actual %0d",
                               $signed(mono_queue[0]), $signed(m_tdata));
                        fail_count <= fail_count + 1;
                    end
                    void'(mono_queue.pop_front());
                end
            end
            if (s_tvalid && s_tready) accumulate_sample(s_tdata, s_tuser);
        end
    end

endmodule

`default_nettype wire

/* bench/tb_pcm_convert_and_downmix_core.sv */
`default_nettype none

module tb_pcm_convert_and_downmix_core;
    import pcd_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int StallLimit = 5000;
    localparam int LongHold = 300;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic        cfg_addr;
    logic [3:0]  cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // sample_word[31:0]
    logic        s_tuser;   // silent
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // mono_sample[15:0]

    int fail_count;
    int pending_count;
    int frame_count;
    int sample_count;
    int idle_cycles;
    bit gaps_on;
    bit hold_req;
    bit float_sel;

    pcm_convert_and_downmix_core i_dut (.*);

    pcd_checker i_checker (.*);

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Sends one sample, after a random gap when gaps are enabled.
    task automatic send_sample(logic [31:0] word, logic silent);
        int n;
        n = gaps_on ? $urandom_range(0, 10) : 0;
        if (n > 0) begin
            s_tvalid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= word;
        s_tuser <= silent;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sample_count++;
    endtask

    // Writes one register once the block has drained.
    task automatic write_reg(logic addr, logic [3:0] data);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr <= addr;
        cfg_wdata <= data;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (addr == CFG_SAMPLE_FORMAT) float_sel = data[0];
    endtask

    // Random sample word, mostly in the useful range for the active format.
    function automatic logic [31:0] random_word();
        logic [31:0] w;
        w = $urandom();
        if (float_sel && $urandom_range(0, 3) != 0)
            w[30:23] = 8'($urandom_range(100, 126));
        return w;
    endfunction

    // Receiver: random stalls, plus one long hold when requested.
    initial begin
        int n;
        m_tready = 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            if (hold_req) n = LongHold;
            else n = gaps_on ? $urandom_range(0, 10) : 0;
            if (n > 0) begin
                m_tready <= 1'b0;
                repeat (n) @(posedge aclk);
                hold_req = 1'b0;
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    // Watchdog on cycles with no transaction on either channel.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= StallLimit) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // Stimulus and verdict.
    initial begin
        logic [3:0] chans;
        int items;
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_addr = CFG_SAMPLE_FORMAT;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        gaps_on = 1'b1;
        hold_req = 1'b0;
        float_sel = 1'b0;
        sample_count = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // PCM extremes at the reset setting of two channels; upper bits ignored.
        send_sample(32'h0000_7FFF, 1'b0);
        send_sample(32'h0000_7FFF, 1'b0);
        send_sample(32'hFFFF_8000, 1'b0);
        send_sample(32'h1234_8000, 1'b0);
        send_sample(32'hABCD_0001, 1'b0);
        send_sample(32'h0000_8000, 1'b1);
        // Single channel passes samples straight through.
        write_reg(CFG_CHANNEL_COUNT, 4'd1);
        send_sample(32'hFFFF_FFFF, 1'b0);
        // Float specials: NaN, infinities, unity, zero, subnormal, rounding.
        write_reg(CFG_SAMPLE_FORMAT, 1'b1);
        send_sample(32'h7FC0_0001, 1'b0);
        send_sample(32'hFFFF_FFFF, 1'b0);
        send_sample(32'h7F80_0000, 1'b0);
        send_sample(32'hFF80_0000, 1'b0);
        send_sample(32'h3F80_0000, 1'b0);
        send_sample(32'hBF80_0000, 1'b0);
        send_sample(32'h4000_0000, 1'b0);
        send_sample(32'h8000_0000, 1'b0);
        send_sample(32'h0000_0001, 1'b0);
        send_sample(32'h3F00_0000, 1'b0);
        send_sample(32'hBF7F_FFFF, 1'b0);
        send_sample(32'h3F80_0000, 1'b1);
        // Zero channel count acts as one, oversize saturates to the maximum.
        write_reg(CFG_CHANNEL_COUNT, 4'd0);
        send_sample(32'h3F40_0000, 1'b0);
        write_reg(CFG_CHANNEL_COUNT, 4'd15);
        repeat (8) send_sample(32'hBF80_0000, 1'b0);

        // Random phases; the format write alone keeps a partial frame open.
        for (int ph = 0; ph < 14; ph++) begin
            case (ph % 7)
                0: chans = 4'd8;
                1: chans = 4'd1;
                2: chans = 4'd0;
                3: chans = 4'd15;
                default: chans = 4'($urandom_range(0, 15));
            endcase
            if (ph % 4 != 3) write_reg(CFG_CHANNEL_COUNT, chans);
            write_reg(CFG_SAMPLE_FORMAT, 4'(ph % 2));
            gaps_on = (ph % 5 != 2);
            if (ph == 4) begin
                gaps_on = 1'b0;
                hold_req = 1'b1;
            end
            items = $urandom_range(55, 75);
            for (int k = 0; k < items; k++)
                send_sample(random_word(), ($urandom_range(0, 7) == 0));
        end
        s_tvalid <= 1'b0;

        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
        $display("Sent %0d samples and checked %0d mono results across PCM and float",
                 sample_count, frame_count);
        $display("modes with channel counts from zero to fifteen, under random stalls.");
        if (fail_count == 0 && pending_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

`default_nettype wire
